// File: rtl/core/assert_macros.svh
// assert_macros.svh: assertion macros for the frame luma mean statistics checks.
// No dependencies; included by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold whenever ante holds in the same cycle
`define FLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fls: same-cycle property violated");

// cons must hold in the cycle after ante
`define FLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fls: next-cycle property violated");

`endif

// File: rtl/core/fls_pkg.sv
// fls_pkg: constants, register indexes and state type for the frame luma mean statistics unit.
// No dependencies.
`default_nettype none

package fls_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 4096;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;

	localparam int unsigned CFG_DIM_W = 13;
	localparam int unsigned ADDR_W    = 4;
	localparam int unsigned DATA_W    = 32;

	localparam int unsigned MEAN_W  = 16;
	localparam int unsigned TALLY_W = 32;
	localparam int unsigned MEANS_W = 48;
	localparam int unsigned DIV_W   = 32;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [MEAN_W-1:0]    FULL_SCALE   = 16'hFF00;
	localparam logic [CFG_DIM_W-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [CFG_DIM_W-1:0] RESET_HEIGHT = 13'd480;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MEAN,
		B_STATS,
		B_AVG,
		B_EMIT
	} back_state_t;

	// 0 becomes 1, anything above maxv becomes maxv
	function automatic logic [CFG_DIM_W:0] clamp_dim(
		input logic [CFG_DIM_W-1:0] v,
		input logic [CFG_DIM_W:0]   maxv
	);
		logic [CFG_DIM_W:0] ext;
		ext = {1'b0, v};
		if (ext == '0)
			return (CFG_DIM_W+1)'(1);
		else if (ext > maxv)
			return maxv;
		else
			return ext;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/fls_if.sv
// fls_if: stream interfaces for pixel bytes in and frame statistics out.
// Depends on fls_pkg for field widths.
`default_nettype none

interface fls_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;

	modport source (output valid, output pixel_byte, input ready);
	modport sink (input valid, input pixel_byte, output ready);
endinterface

interface fls_stats_if;
	logic                               valid;
	logic                               ready;
	logic [fls_pkg::MEAN_W-1:0]         frame_mean;
	logic [fls_pkg::TALLY_W-1:0]        frames_done;
	logic [fls_pkg::MEAN_W-1:0]         mean_of_frames;
	logic [fls_pkg::MEAN_W-1:0]         lowest_mean;
	logic [fls_pkg::MEAN_W-1:0]         highest_mean;

	modport source (output valid, output frame_mean, output frames_done,
		output mean_of_frames, output lowest_mean, output highest_mean, input ready);
	modport sink (input valid, input frame_mean, input frames_done,
		input mean_of_frames, input lowest_mean, input highest_mean, output ready);
endinterface

`default_nettype wire

// File: rtl/core/frame_luma_mean_stats_unit.sv
// Throughput: one byte per cycle while the frame queue has room; per frame the back end
//   runs two 16-step divisions, a stats update and an output load.
// Frames that arrive faster than the back end drains them fill the 4-entry queue and then stall the input.
// Reset (arst_n, async): format YUYV, 640x480, no frame in progress,
//   statistics cleared (lowest mean 255.0, highest 0).
`default_nettype none

module frame_luma_mean_stats_unit #(
	parameter int unsigned MAX_WIDTH  = fls_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = fls_pkg::DEF_MAX_HEIGHT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fls_pkg::ADDR_W-1:0]  paddr,
	input  logic [fls_pkg::DATA_W-1:0]  pwdata,
	output logic [fls_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	fls_pix_if.sink                     pixels,
	fls_stats_if.source                 stats
);

	localparam int unsigned DIM_W = fls_pkg::CFG_DIM_W;
	localparam int unsigned PIX_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int unsigned SUM_W = PIX_W + 8;

	// reset size, clamped to the build limits
	localparam int unsigned RST_W   = (32'(fls_pkg::RESET_WIDTH) > MAX_WIDTH) ?
		MAX_WIDTH : 32'(fls_pkg::RESET_WIDTH);
	localparam int unsigned RST_H   = (32'(fls_pkg::RESET_HEIGHT) > MAX_HEIGHT) ?
		MAX_HEIGHT : 32'(fls_pkg::RESET_HEIGHT);
	localparam int unsigned RST_PIX = RST_W * RST_H;

	logic             fmt_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [PIX_W-1:0] pix_q;
	logic [PIX_W:0]   frame_bytes_q;

	logic             wr;
	logic             wr_hit;
	logic [1:0]       idx;
	logic             fmt_nx;
	logic [DIM_W-1:0] width_nx;
	logic [DIM_W-1:0] height_nx;
	logic [DIM_W:0]   w_cl;
	logic [DIM_W:0]   h_cl;
	logic [PIX_W-1:0] pix_nx;

	logic             push;
	logic [SUM_W-1:0] push_sum;
	logic [PIX_W-1:0] push_pix;
	logic             pop;
	logic             full;
	logic             empty;
	logic [SUM_W+PIX_W-1:0] head;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign wr_hit = wr && (idx == fls_pkg::REG_FORMAT || idx == fls_pkg::REG_WIDTH ||
		idx == fls_pkg::REG_HEIGHT);

	always_comb begin
		fmt_nx    = fmt_q;
		width_nx  = width_q;
		height_nx = height_q;
		if (wr) begin
			unique case (idx)
				fls_pkg::REG_FORMAT: fmt_nx    = pwdata[0];
				fls_pkg::REG_WIDTH:  width_nx  = pwdata[DIM_W-1:0];
				fls_pkg::REG_HEIGHT: height_nx = pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
		w_cl   = fls_pkg::clamp_dim(width_nx, (DIM_W+1)'(MAX_WIDTH));
		h_cl   = fls_pkg::clamp_dim(height_nx, (DIM_W+1)'(MAX_HEIGHT));
		pix_nx = PIX_W'(w_cl) * PIX_W'(h_cl);
	end

	always_comb begin
		unique case (idx)
			fls_pkg::REG_FORMAT: prdata = fls_pkg::DATA_W'(fmt_q);
			fls_pkg::REG_WIDTH:  prdata = fls_pkg::DATA_W'(width_q);
			fls_pkg::REG_HEIGHT: prdata = fls_pkg::DATA_W'(height_q);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q         <= 1'b0;
			width_q       <= fls_pkg::RESET_WIDTH;
			height_q      <= fls_pkg::RESET_HEIGHT;
			pix_q         <= PIX_W'(RST_PIX);
			frame_bytes_q <= (PIX_W+1)'(2 * RST_PIX);
		end else if (wr_hit) begin
			fmt_q         <= fmt_nx;
			width_q       <= width_nx;
			height_q      <= height_nx;
			pix_q         <= pix_nx;
			frame_bytes_q <= fmt_nx ? {1'b0, pix_nx} : {pix_nx, 1'b0};
		end
	end

	fls_front #(.PIX_W(PIX_W)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr         (wr_hit),
		.fmt         (fmt_q),
		.frame_bytes (frame_bytes_q),
		.pix         (pix_q),
		.full        (full),
		.push        (push),
		.push_sum    (push_sum),
		.push_pix    (push_pix),
		.pixels      (pixels)
	);

	fls_fifo #(
		.WIDTH (SUM_W + PIX_W),
		.DEPTH (fls_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_sum, push_pix}),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	fls_back #(.PIX_W(PIX_W)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.q_sum  (head[SUM_W+PIX_W-1:PIX_W]),
		.q_pix  (head[PIX_W-1:0]),
		.pop    (pop),
		.stats  (stats)
	);

endmodule

`default_nettype wire

// File: rtl/core/fls_fifo.sv
// fls_fifo: short register queue of finished frame sums between front and back.
// Depends on fls_pkg for the default depth.
`default_nettype none

module fls_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = fls_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop && !empty)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/fls_div.sv
// fls_div: restoring divider, one quotient bit per cycle, 16-bit quotient.
// Requires hi < den on start. Depends on fls_pkg.
`default_nettype none

module fls_div #(
	parameter int unsigned DW = fls_pkg::DIV_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DW-1:0]              hi,
	input  logic [fls_pkg::MEAN_W-1:0] lo,
	input  logic [DW-1:0]              den,
	output logic                       done,
	output logic [fls_pkg::MEAN_W-1:0] quot
);

	localparam int unsigned QW    = fls_pkg::MEAN_W;
	localparam int unsigned CNT_W = $clog2(QW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [QW-1:0]    lo_q;
	logic [QW-1:0]    quot_q;

	logic [DW:0]      trial;
	logic             ge;
	logic [DW-1:0]    rem_nx;

	always_comb begin
		trial  = {rem_q, lo_q[QW-1]};
		ge     = (trial >= {1'b0, den_q});
		rem_nx = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q  <= hi;
			den_q  <= den;
			lo_q   <= lo;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			lo_q   <= {lo_q[QW-2:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// File: rtl/core/fls_front.sv
// fls_front: takes one byte per beat, sums luma, and queues the sum at frame end.
// Depends on fls_pix_if.
`default_nettype none

module fls_front #(
	parameter int unsigned PIX_W = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic               fmt,
	input  logic [PIX_W:0]     frame_bytes,
	input  logic [PIX_W-1:0]   pix,
	input  logic               full,
	output logic               push,
	output logic [PIX_W+7:0]   push_sum,
	output logic [PIX_W-1:0]   push_pix,
	fls_pix_if.sink            pixels
);

	logic [PIX_W:0]   pos_q;
	logic [PIX_W+7:0] sum_q;

	logic             accept;
	logic             luma;
	logic [PIX_W:0]   pos_nx;
	logic [PIX_W+7:0] sum_nx;
	logic             last;

	assign pixels.ready = !full;
	assign accept       = pixels.valid && !full;

	always_comb begin
		luma   = fmt || !pos_q[0];
		pos_nx = pos_q + 1'b1;
		sum_nx = luma ? sum_q + (PIX_W+8)'(pixels.pixel_byte) : sum_q;
		last   = (pos_nx == frame_bytes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (clr) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_nx;
				sum_q <= sum_nx;
			end
		end
	end

	assign push     = accept && last;
	assign push_sum = sum_nx;
	assign push_pix = pix;

endmodule

`default_nettype wire

// File: rtl/core/fls_back.sv
// fls_back: per-frame mean, running statistics and mean of means, with output register.
// Depends on fls_pkg, fls_stats_if and fls_div.
`default_nettype none

module fls_back #(
	parameter int unsigned PIX_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  logic [PIX_W+7:0] q_sum,
	input  logic [PIX_W-1:0] q_pix,
	output logic             pop,
	fls_stats_if.source      stats
);

	localparam int unsigned MW = fls_pkg::MEAN_W;
	localparam int unsigned TW = fls_pkg::TALLY_W;
	localparam int unsigned SW = fls_pkg::MEANS_W;
	localparam int unsigned DW = fls_pkg::DIV_W;

	fls_pkg::back_state_t state_q, state_nx;

	logic [MW-1:0] mean_q;
	logic [TW-1:0] tally_q;
	logic [SW-1:0] means_q;
	logic [MW-1:0] low_q;
	logic [MW-1:0] high_q;

	logic          ov_q;
	logic [MW-1:0] o_mean_q;
	logic [TW-1:0] o_done_q;
	logic [MW-1:0] o_avg_q;
	logic [MW-1:0] o_low_q;
	logic [MW-1:0] o_high_q;

	logic          div_start;
	logic [DW-1:0] div_hi;
	logic [MW-1:0] div_lo;
	logic [DW-1:0] div_den;
	logic          div_done;
	logic [MW-1:0] div_quot;

	logic          stats_en;
	logic          load_out;
	logic          out_free;
	logic          tally_sat;
	logic [TW-1:0] tally_nx;
	logic [SW-1:0] means_nx;

	assign out_free  = !ov_q || stats.ready;
	assign tally_sat = (tally_q == '1);
	assign tally_nx  = tally_sat ? tally_q : tally_q + 1'b1;
	assign means_nx  = tally_sat ? means_q : means_q + SW'(mean_q);

	fls_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.hi     (div_hi),
		.lo     (div_lo),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			fls_pkg::B_IDLE:  if (!empty) state_nx = fls_pkg::B_MEAN;
			fls_pkg::B_MEAN:  if (div_done) state_nx = fls_pkg::B_STATS;
			fls_pkg::B_STATS: state_nx = fls_pkg::B_AVG;
			fls_pkg::B_AVG:   if (div_done) state_nx = fls_pkg::B_EMIT;
			fls_pkg::B_EMIT:  if (out_free) state_nx = fls_pkg::B_IDLE;
			default:          state_nx = fls_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		stats_en  = 1'b0;
		load_out  = 1'b0;
		// mean: (sum << 8) / pixels, upper part sum >> 8 is below pixels
		div_hi    = DW'(q_sum[PIX_W+7:8]);
		div_lo    = {q_sum[7:0], 8'h00};
		div_den   = DW'(q_pix);
		unique case (state_q)
			fls_pkg::B_IDLE: begin
				pop       = !empty;
				div_start = !empty;
			end
			fls_pkg::B_STATS: begin
				stats_en  = 1'b1;
				div_start = 1'b1;
				div_hi    = means_nx[SW-1:MW];
				div_lo    = means_nx[MW-1:0];
				div_den   = tally_nx;
			end
			fls_pkg::B_EMIT: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fls_pkg::B_IDLE;
			tally_q <= '0;
			means_q <= '0;
			low_q   <= fls_pkg::FULL_SCALE;
			high_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (stats_en) begin
				tally_q <= tally_nx;
				means_q <= means_nx;
				if (mean_q < low_q)
					low_q <= mean_q;
				if (mean_q > high_q)
					high_q <= mean_q;
			end
			if (load_out)
				ov_q <= 1'b1;
			else if (stats.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fls_pkg::B_MEAN && div_done)
			mean_q <= div_quot;
		if (load_out) begin
			o_mean_q <= mean_q;
			o_done_q <= tally_q;
			o_avg_q  <= div_quot;
			o_low_q  <= low_q;
			o_high_q <= high_q;
		end
	end

	assign stats.valid          = ov_q;
	assign stats.frame_mean     = o_mean_q;
	assign stats.frames_done    = o_done_q;
	assign stats.mean_of_frames = o_avg_q;
	assign stats.lowest_mean    = o_low_q;
	assign stats.highest_mean   = o_high_q;

endmodule

`default_nettype wire

// File: rtl/core/fls_checker.sv
// fls_checker: port-level checks on the statistics beats, bound to the top level.
// Depends on assert_macros.svh and fls_pkg.
`default_nettype none
`include "assert_macros.svh"

module fls_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         valid,
	input wire logic                         ready,
	input wire logic [fls_pkg::MEAN_W-1:0]   frame_mean,
	input wire logic [fls_pkg::TALLY_W-1:0]  frames_done,
	input wire logic [fls_pkg::MEAN_W-1:0]   mean_of_frames,
	input wire logic [fls_pkg::MEAN_W-1:0]   lowest_mean,
	input wire logic [fls_pkg::MEAN_W-1:0]   highest_mean
);

	`FLS_ASSERT_NEXT(a_beat_held, clk, arst_n, valid && !ready, valid && $stable(frame_mean) && $stable(frames_done))
	`FLS_ASSERT_IMPL(a_low_le_high, clk, arst_n, valid, lowest_mean <= highest_mean)
	`FLS_ASSERT_IMPL(a_mean_in_range, clk, arst_n, valid, frame_mean >= lowest_mean && frame_mean <= highest_mean)
	`FLS_ASSERT_IMPL(a_avg_in_range, clk, arst_n, valid, mean_of_frames >= lowest_mean && mean_of_frames <= highest_mean)
	`FLS_ASSERT_IMPL(a_tally_nonzero, clk, arst_n, valid, frames_done != '0)

endmodule

bind frame_luma_mean_stats_unit fls_checker u_fls_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (stats.valid),
	.ready          (stats.ready),
	.frame_mean     (stats.frame_mean),
	.frames_done    (stats.frames_done),
	.mean_of_frames (stats.mean_of_frames),
	.lowest_mean    (stats.lowest_mean),
	.highest_mean   (stats.highest_mean)
);

`default_nettype wire
